// ===== src/htsc_pkg.sv =====
// Package for the hour timer switch controller: codes, item and result types,
// and the small BCD and hour helpers. No dependencies.
`default_nettype none

package htsc_pkg;

    // Mode button must read high on this many polls in a row to toggle
    localparam int HOLD_POLLS = 3;
    localparam int HOLD_W     = $clog2(HOLD_POLLS + 1);

    // Item kinds
    localparam logic [1:0] ACT_POLL = 2'd0;
    localparam logic [1:0] ACT_KEY1 = 2'd1;
    localparam logic [1:0] ACT_KEY2 = 2'd2;

    // Menu stages
    localparam logic [1:0] STG_INIT   = 2'd0;
    localparam logic [1:0] STG_CHOOSE = 2'd1;
    localparam logic [1:0] STG_EDIT   = 2'd2;

    // Channels
    localparam logic [1:0] CH_LED = 2'd1;
    localparam logic [1:0] CH_FAN = 2'd2;

    // RTC write requests
    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_MINUTE = 2'd1;
    localparam logic [1:0] WR_HOUR   = 2'd2;

    localparam logic [4:0] HOURS_PER_DAY = 5'd24;
    localparam logic [6:0] MINUTE_MAX    = 7'd59;
    localparam logic [5:0] HOUR_MAX      = 6'd23;

    // Field widths of the stream words
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [1:0] action;
        logic       mode_pin;
        logic [5:0] rtc_hour_bcd;
        logic [6:0] rtc_minute_bcd;
    } t_in_item;

    typedef struct packed {
        logic       led_drive;
        logic       fan_drive;
        logic       setting_mode;
        logic [1:0] menu_stage;
        logic [1:0] chosen_channel;
        logic [1:0] rtc_write_kind;
        logic [5:0] rtc_write_value;
        logic [4:0] shown_on_hour;
        logic [4:0] shown_off_hour;
    } t_result;

    // Binary hour (0..31) to two BCD digits
    function automatic logic [5:0] to_bcd(input logic [4:0] h);
        logic [1:0] hi;
        logic [4:0] rem;
        begin
            if (h >= 5'd30) begin
                hi = 2'd3;
            end else if (h >= 5'd20) begin
                hi = 2'd2;
            end else if (h >= 5'd10) begin
                hi = 2'd1;
            end else begin
                hi = 2'd0;
            end
            rem = h - 5'({3'd0, hi} * 5'd10);
            return {hi, rem[3:0]};
        end
    endfunction

    // Step an hour setting, wrapping at midnight
    function automatic logic [4:0] hour_step(input logic [4:0] h);
        logic [5:0] s;
        begin
            s = {1'b0, h} + 6'd1;
            return (s >= {1'b0, HOURS_PER_DAY}) ? 5'd0 : s[4:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/htsc_in_stage.sv =====
// Input register of the hour timer switch controller: holds one transfer
// until the step logic takes it. Depends on htsc_pkg.
`default_nettype none

module htsc_in_stage
    import htsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    input  wire logic     i_advance,
    output logic          o_valid,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/htsc_step.sv =====
// Controller state and the one-item update: mode debounce, channel compare,
// RTC increment requests and the setting menu. Depends on htsc_pkg.
`default_nettype none

module htsc_step
    import htsc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_fire,
    input  wire t_in_item i_item,
    output t_result       o_result
);

    logic              r_mode, n_mode;
    logic [HOLD_W-1:0] r_hold, n_hold;
    logic [1:0]        r_stage, n_stage;
    logic [1:0]        r_pick, n_pick;
    logic              r_enter, n_enter;
    logic [4:0]        r_led_on, n_led_on, r_led_off, n_led_off;
    logic [4:0]        r_fan_on, n_fan_on, r_fan_off, n_fan_off;
    logic [5:0]        r_last_hour, n_last_hour;
    logic [6:0]        r_last_min, n_last_min;
    logic              r_led, n_led, r_fan, n_fan;

    logic [HOLD_W-1:0] hold_inc;
    logic [1:0]        pick_inc;
    logic [6:0]        min_inc;
    logic [5:0]        hour_inc;
    logic [1:0]        wkind;
    logic [5:0]        wval;

    // BCD increments of the sampled time; a bad low digit carries
    always_comb begin
        if (r_last_min[3:0] > 4'd9) begin
            min_inc = 7'(({4'd0, r_last_min[6:4]} + 7'd1) * 7'd10);
        end else begin
            min_inc = 7'({4'd0, r_last_min[6:4]} * 7'd10) + {3'd0, r_last_min[3:0]} + 7'd1;
        end
        if (r_last_hour[3:0] > 4'd9) begin
            hour_inc = 6'(({4'd0, r_last_hour[5:4]} + 6'd1) * 6'd10);
        end else begin
            hour_inc = 6'({4'd0, r_last_hour[5:4]} * 6'd10) + {2'd0, r_last_hour[3:0]} + 6'd1;
        end
    end

    assign hold_inc = r_hold + HOLD_W'(1);
    assign pick_inc = r_pick + 2'd1;

    always_comb begin
        n_mode      = r_mode;
        n_hold      = r_hold;
        n_stage     = r_stage;
        n_pick      = r_pick;
        n_enter     = r_enter;
        n_led_on    = r_led_on;
        n_led_off   = r_led_off;
        n_fan_on    = r_fan_on;
        n_fan_off   = r_fan_off;
        n_last_hour = r_last_hour;
        n_last_min  = r_last_min;
        n_led       = r_led;
        n_fan       = r_fan;
        wkind       = WR_NONE;
        wval        = 6'd0;

        case (i_item.action)
            ACT_POLL: begin
                // debounce first; toggling restarts the menu
                if (i_item.mode_pin) begin
                    n_hold = hold_inc;
                    if (hold_inc >= HOLD_W'(HOLD_POLLS)) begin
                        n_hold  = '0;
                        n_stage = STG_INIT;
                        n_mode  = !r_mode;
                    end
                end else begin
                    n_hold = '0;
                end
                if (!n_mode) begin
                    n_last_hour = i_item.rtc_hour_bcd;
                    n_last_min  = i_item.rtc_minute_bcd;
                    if (i_item.rtc_hour_bcd == to_bcd(r_led_on)) begin
                        n_led = 1'b1;
                    end else if (i_item.rtc_hour_bcd == to_bcd(r_led_off)) begin
                        n_led = 1'b0;
                    end
                    if (i_item.rtc_hour_bcd == to_bcd(r_fan_on)) begin
                        n_fan = 1'b1;
                    end else if (i_item.rtc_hour_bcd == to_bcd(r_fan_off)) begin
                        n_fan = 1'b0;
                    end
                end else if (n_stage == STG_INIT) begin
                    n_stage = STG_CHOOSE;
                end else if (n_stage == STG_CHOOSE && r_enter) begin
                    n_enter = 1'b0;
                    if (r_pick == CH_LED || r_pick == CH_FAN) begin
                        n_stage = STG_EDIT;
                    end
                end
            end
            ACT_KEY1: begin
                if (!r_mode) begin
                    wkind = WR_MINUTE;
                    if (min_inc > MINUTE_MAX) begin
                        n_last_min = 7'd0;
                    end else begin
                        wval = min_inc[5:0];
                    end
                end else if (r_stage == STG_CHOOSE) begin
                    n_enter = 1'b1;
                end else if (r_stage == STG_EDIT) begin
                    if (r_pick == CH_LED) begin
                        n_led_off = hour_step(r_led_off);
                    end else if (r_pick == CH_FAN) begin
                        n_fan_off = hour_step(r_fan_off);
                    end
                end else begin
                    n_enter = 1'b0;
                end
            end
            ACT_KEY2: begin
                if (!r_mode) begin
                    wkind = WR_HOUR;
                    if (hour_inc <= HOUR_MAX) begin
                        wval = hour_inc;
                    end
                end else if (r_stage == STG_CHOOSE) begin
                    n_pick = (pick_inc == 2'd3) ? CH_LED : pick_inc;
                end else if (r_stage == STG_EDIT) begin
                    if (r_pick == CH_LED) begin
                        n_led_on = hour_step(r_led_on);
                    end else if (r_pick == CH_FAN) begin
                        n_fan_on = hour_step(r_fan_on);
                    end
                end
            end
            default: begin
                // unused code: leave the state alone
            end
        endcase
    end

    always_comb begin
        o_result.led_drive       = n_led;
        o_result.fan_drive       = n_fan;
        o_result.setting_mode    = n_mode;
        o_result.menu_stage      = n_stage;
        o_result.chosen_channel  = n_pick;
        o_result.rtc_write_kind  = wkind;
        o_result.rtc_write_value = wval;
        case (n_pick)
            CH_LED: begin
                o_result.shown_on_hour  = n_led_on;
                o_result.shown_off_hour = n_led_off;
            end
            CH_FAN: begin
                o_result.shown_on_hour  = n_fan_on;
                o_result.shown_off_hour = n_fan_off;
            end
            default: begin
                o_result.shown_on_hour  = 5'd0;
                o_result.shown_off_hour = 5'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_hold      <= '0;
            r_stage     <= STG_INIT;
            r_pick      <= CH_LED;
            r_enter     <= 1'b0;
            r_led_on    <= 5'd1;
            r_led_off   <= 5'd2;
            r_fan_on    <= 5'd1;
            r_fan_off   <= 5'd2;
            r_last_hour <= 6'd0;
            r_last_min  <= 7'd0;
            r_led       <= 1'b0;
            r_fan       <= 1'b0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_hold      <= n_hold;
            r_stage     <= n_stage;
            r_pick      <= n_pick;
            r_enter     <= n_enter;
            r_led_on    <= n_led_on;
            r_led_off   <= n_led_off;
            r_fan_on    <= n_fan_on;
            r_fan_off   <= n_fan_off;
            r_last_hour <= n_last_hour;
            r_last_min  <= n_last_min;
            r_led       <= n_led;
            r_fan       <= n_fan;
        end
    end

endmodule

`default_nettype wire

// ===== src/htsc_out_stage.sv =====
// Result register of the hour timer switch controller: holds one result
// until the receiver takes it. Depends on htsc_pkg.
`default_nettype none

module htsc_out_stage
    import htsc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_result,
    output logic         o_advance,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== src/hour_timer_switch_controller_core.sv =====
// Top level of the hour timer switch controller: input register, step logic
// and result register. Depends on htsc_pkg, htsc_in_stage, htsc_step, htsc_out_stage.
//
// Use: one input transfer per event on the s_axis side; tuser carries the
// event kind (poll, key1, key2), tdata the mode button level and the RTC
// hour and minute in BCD. Every event gives exactly one result transfer on
// the m_axis side: channel levels, mode, menu stage, chosen channel, RTC
// write value and shown hours in tdata, the RTC write request kind in tuser.
// The event sits in the input register and passes through the state update
// into the result register once that register is free or its result is taken.
// Throughput: one event per cycle while the receiver takes every result,
// bounded by the single state update that each event needs before the next.
// Reset clears both registers' valid flags and returns the controller
// state to time mode with the default channel hours.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more event if it is empty; once it is full, tready
// drops until the result is taken.
`default_nettype none

module hour_timer_switch_controller_core
    import htsc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [0] mode_pin, [6:1] rtc_hour_bcd, [13:7] rtc_minute_bcd, [15:14] zero
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]            i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [0] led_drive, [1] fan_drive, [2] setting_mode, [4:3] menu_stage,
    // [6:5] chosen_channel, [12:7] rtc_write_value, [17:13] shown_on_hour,
    // [22:18] shown_off_hour, [23] zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // [1:0] rtc_write_kind
    output logic [1:0]                 o_m_axis_tuser
);

    t_in_item in_item, held_item;
    t_result  step_result, out_result;
    logic     held_valid, advance;

    always_comb begin
        in_item.action         = i_s_axis_tuser;
        in_item.mode_pin       = i_s_axis_tdata[0];
        in_item.rtc_hour_bcd   = i_s_axis_tdata[6:1];
        in_item.rtc_minute_bcd = i_s_axis_tdata[13:7];
    end

    htsc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    htsc_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (held_valid && advance),
        .i_item   (held_item),
        .o_result (step_result)
    );

    htsc_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (held_valid),
        .i_result  (step_result),
        .o_advance (advance),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (out_result)
    );

    assign o_m_axis_tdata = {1'b0,
                             out_result.shown_off_hour,
                             out_result.shown_on_hour,
                             out_result.rtc_write_value,
                             out_result.chosen_channel,
                             out_result.menu_stage,
                             out_result.setting_mode,
                             out_result.fan_drive,
                             out_result.led_drive};
    assign o_m_axis_tuser = out_result.rtc_write_kind;

    // RTC writes are only requested in time mode
    a_write_time_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != WR_NONE) |-> !o_m_axis_tdata[2])
        else $error("RTC write requested in setting mode");

    // Menu never reaches the unused stage code and the channel stays in range
    a_menu_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[4:3] != 2'd3 &&
                             (o_m_axis_tdata[6:5] == CH_LED || o_m_axis_tdata[6:5] == CH_FAN)))
        else $error("menu stage or channel out of range");

    // With both registers full and the receiver stalled, no transfer is taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while pipeline full");

    // A stalled result is followed by a valid result: nothing is dropped
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("stalled result lost");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking bench for hour_timer_switch_controller_core: directed table then random events,
// each result compared against the table's expected status (typed rows) or an in-bench model
// of the mode, menu and channel logic. Depends on htsc_pkg and the core RTL only.
`default_nettype none

module tb_top;
    import htsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Ignored event code, not in the package
    localparam logic [1:0] ACT_NOP = 2'd3;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_EVENTS   = 1800;
    localparam int MAX_REPORTS     = 30;

    typedef struct packed {
        t_in_item ev;
        logic     typed;
        t_result  want;
    } t_stim_row;

    localparam t_result NO_WANT      = '0;
    localparam t_result RESET_STATUS =
        {1'b0, 1'b0, 1'b0, STG_INIT, CH_LED, WR_NONE, 6'd0, 5'd1, 5'd2};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_count = 0;
    int fault_count = 0;
    int event_count = 0;
    int result_count = 0;
    int rtc_writes = 0;
    int mode_changes = 0;
    int edit_entries = 0;

    // Controller model state
    int         hold_run = 0;
    logic       in_setting = 1'b0;
    logic [1:0] menu_step = STG_INIT;
    logic [1:0] pick_ch = CH_LED;
    logic       enter_pending = 1'b0;
    logic [4:0] led_on_h = 5'd1;
    logic [4:0] led_off_h = 5'd2;
    logic [4:0] fan_on_h = 5'd1;
    logic [4:0] fan_off_h = 5'd2;
    logic [5:0] seen_hour = '0;
    logic [6:0] seen_minute = '0;
    logic       led_lvl = 1'b0;
    logic       fan_lvl = 1'b0;

    t_result due_status_q[$];

    t_stim_row directed_rows [26] = '{
        {{ACT_NOP,  1'b1, 6'h3f, 7'h7f}, 1'b1, RESET_STATUS},
        {{ACT_KEY1, 1'b0, 6'h00, 7'h00}, 1'b1,
            {1'b0, 1'b0, 1'b0, STG_INIT, CH_LED, WR_MINUTE, 6'd1, 5'd1, 5'd2}},
        {{ACT_KEY2, 1'b1, 6'h3f, 7'h7f}, 1'b1,
            {1'b0, 1'b0, 1'b0, STG_INIT, CH_LED, WR_HOUR, 6'd1, 5'd1, 5'd2}},
        {{ACT_POLL, 1'b0, 6'h01, 7'h59}, 1'b1,
            {1'b1, 1'b1, 1'b0, STG_INIT, CH_LED, WR_NONE, 6'd0, 5'd1, 5'd2}},
        {{ACT_KEY1, 1'b0, 6'h00, 7'h00}, 1'b1,
            {1'b1, 1'b1, 1'b0, STG_INIT, CH_LED, WR_MINUTE, 6'd0, 5'd1, 5'd2}},
        {{ACT_POLL, 1'b0, 6'h02, 7'h7f}, 1'b1,
            {1'b0, 1'b0, 1'b0, STG_INIT, CH_LED, WR_NONE, 6'd0, 5'd1, 5'd2}},
        {{ACT_KEY1, 1'b0, 6'h15, 7'h2a}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b0, 6'h3f, 7'h1a}, 1'b0, NO_WANT},
        {{ACT_KEY1, 1'b1, 6'h00, 7'h00}, 1'b0, NO_WANT},
        {{ACT_KEY2, 1'b0, 6'h2a, 7'h55}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b0, 6'h29, 7'h00}, 1'b0, NO_WANT},
        {{ACT_KEY2, 1'b0, 6'h00, 7'h00}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b1, 6'h01, 7'h00}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b0, 6'h01, 7'h00}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b1, 6'h02, 7'h30}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b1, 6'h02, 7'h30}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b1, 6'h23, 7'h59}, 1'b0, NO_WANT},
        {{ACT_NOP,  1'b1, 6'h10, 7'h10}, 1'b0, NO_WANT},
        {{ACT_KEY2, 1'b0, 6'h00, 7'h00}, 1'b0, NO_WANT},
        {{ACT_KEY1, 1'b0, 6'h00, 7'h00}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b0, 6'h05, 7'h05}, 1'b0, NO_WANT},
        {{ACT_KEY2, 1'b0, 6'h00, 7'h00}, 1'b0, NO_WANT},
        {{ACT_KEY1, 1'b0, 6'h00, 7'h00}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b1, 6'h02, 7'h00}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b1, 6'h02, 7'h00}, 1'b0, NO_WANT},
        {{ACT_POLL, 1'b1, 6'h02, 7'h00}, 1'b0, NO_WANT}
    };

    hour_timer_switch_controller_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [6:0] as_bcd(input int v);
        return 7'(((v / 10) << 4) | (v % 10));
    endfunction

    // Increment a BCD value; an invalid low digit carries and becomes zero
    function automatic int bcd_next(input logic [6:0] v, input logic [3:0] hi_mask);
        int lo;
        int hi;
        begin
            lo = int'(v[3:0]);
            hi = int'((v >> 4) & {3'd0, hi_mask});
            if (lo > 9) begin
                hi = hi + 1;
                lo = 0;
            end else begin
                lo = lo + 1;
            end
            return hi * 10 + lo;
        end
    endfunction

    function automatic logic [4:0] next_hour(input logic [4:0] h);
        return (h >= 5'd23) ? 5'd0 : h + 5'd1;
    endfunction

    // Advance the controller model by one event and return the status it shows
    function automatic t_result next_controller_status(input t_in_item ev);
        t_result r;
        logic [1:0] wkind;
        int wval;
        begin
            wkind = WR_NONE;
            wval = 0;
            case (ev.action)
                ACT_POLL: begin
                    if (ev.mode_pin) begin
                        hold_run++;
                        if (hold_run >= HOLD_POLLS) begin
                            hold_run = 0;
                            menu_step = STG_INIT;
                            in_setting = !in_setting;
                            mode_changes++;
                        end
                    end else begin
                        hold_run = 0;
                    end
                    // Time mode samples the clock in the same poll as the toggle
                    if (!in_setting) begin
                        seen_hour = ev.rtc_hour_bcd;
                        seen_minute = ev.rtc_minute_bcd;
                        if ({1'b0, seen_hour} == as_bcd(led_on_h)) begin
                            led_lvl = 1'b1;
                        end else if ({1'b0, seen_hour} == as_bcd(led_off_h)) begin
                            led_lvl = 1'b0;
                        end
                        if ({1'b0, seen_hour} == as_bcd(fan_on_h)) begin
                            fan_lvl = 1'b1;
                        end else if ({1'b0, seen_hour} == as_bcd(fan_off_h)) begin
                            fan_lvl = 1'b0;
                        end
                    end else if (menu_step == STG_INIT) begin
                        menu_step = STG_CHOOSE;
                    end else if (menu_step == STG_CHOOSE && enter_pending) begin
                        enter_pending = 1'b0;
                        if (pick_ch == CH_LED || pick_ch == CH_FAN) begin
                            menu_step = STG_EDIT;
                            edit_entries++;
                        end
                    end
                end
                ACT_KEY1: begin
                    if (!in_setting) begin
                        wval = bcd_next(seen_minute, 4'hf);
                        if (wval > 59) begin
                            wval = 0;
                            seen_minute = '0;
                        end
                        wkind = WR_MINUTE;
                    end else if (menu_step == STG_CHOOSE) begin
                        enter_pending = 1'b1;
                    end else if (menu_step == STG_EDIT) begin
                        if (pick_ch == CH_LED) begin
                            led_off_h = next_hour(led_off_h);
                        end else if (pick_ch == CH_FAN) begin
                            fan_off_h = next_hour(fan_off_h);
                        end
                    end else begin
                        enter_pending = 1'b0;
                    end
                end
                ACT_KEY2: begin
                    if (!in_setting) begin
                        // Hour write leaves the sampled hour alone until the next poll
                        wval = bcd_next({1'b0, seen_hour}, 4'h3);
                        if (wval > 23) begin
                            wval = 0;
                        end
                        wkind = WR_HOUR;
                    end else if (menu_step == STG_CHOOSE) begin
                        pick_ch = pick_ch + 2'd1;
                        if (pick_ch == 2'd3) begin
                            pick_ch = CH_LED;
                        end
                    end else if (menu_step == STG_EDIT) begin
                        if (pick_ch == CH_LED) begin
                            led_on_h = next_hour(led_on_h);
                        end else if (pick_ch == CH_FAN) begin
                            fan_on_h = next_hour(fan_on_h);
                        end
                    end
                end
                default: begin
                end
            endcase
            if (wkind != WR_NONE) begin
                rtc_writes++;
            end
            r.led_drive = led_lvl;
            r.fan_drive = fan_lvl;
            r.setting_mode = in_setting;
            r.menu_stage = menu_step;
            r.chosen_channel = pick_ch;
            r.rtc_write_kind = wkind;
            r.rtc_write_value = 6'(wval);
            if (pick_ch == CH_LED) begin
                r.shown_on_hour = led_on_h;
                r.shown_off_hour = led_off_h;
            end else if (pick_ch == CH_FAN) begin
                r.shown_on_hour = fan_on_h;
                r.shown_off_hour = fan_off_h;
            end else begin
                r.shown_on_hour = '0;
                r.shown_off_hour = '0;
            end
            return r;
        end
    endfunction

    function automatic t_in_item random_event();
        t_in_item ev;
        int pick;
        begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                ev.action = ACT_POLL;
            end else if (pick < 70) begin
                ev.action = ACT_KEY1;
            end else if (pick < 95) begin
                ev.action = ACT_KEY2;
            end else begin
                ev.action = ACT_NOP;
            end
            ev.mode_pin = ($urandom_range(3) == 0);
            // Mostly well-formed clock readings so that hour matches happen
            ev.rtc_hour_bcd = ($urandom_range(9) < 7) ? 6'(as_bcd($urandom_range(23)))
                                                       : 6'($urandom_range(63));
            ev.rtc_minute_bcd = ($urandom_range(9) < 7) ? as_bcd($urandom_range(59))
                                                         : 7'($urandom_range(127));
            return ev;
        end
    endfunction

    // Present one event, hold it until the transfer, then predict its status
    task automatic deliver_event(input t_in_item ev, input logic typed, input t_result want);
        t_result predicted;
        begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= {2'b00, ev.rtc_minute_bcd, ev.rtc_hour_bcd, ev.mode_pin};
            s_tuser <= ev.action;
            do @(posedge i_clk); while (!s_tready);
            predicted = next_controller_status(ev);
            due_status_q.push_back(typed ? want : predicted);
            event_count++;
            @(negedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
                $display("%0t ns: result %0d %s mismatch, expected %0d, actual %0d",
                         $time, result_count, name, want, got);
            end
        end
    endtask

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped at cycle limit with %0d results outstanding",
                     due_status_q.size());
            $display("FAIL hour_timer_switch_controller_core");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result due;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (due_status_q.size() == 0) begin
                fault_count++;
                $display("%0t ns: unexpected result, expected none, actual tdata %h tuser %0d",
                         $time, m_tdata, m_tuser);
            end else begin
                due = due_status_q.pop_front();
                check_field("led_drive", due.led_drive, m_tdata[0]);
                check_field("fan_drive", due.fan_drive, m_tdata[1]);
                check_field("setting_mode", due.setting_mode, m_tdata[2]);
                check_field("menu_stage", due.menu_stage, m_tdata[4:3]);
                check_field("chosen_channel", due.chosen_channel, m_tdata[6:5]);
                check_field("rtc_write_kind", due.rtc_write_kind, m_tuser);
                check_field("rtc_write_value", due.rtc_write_value, m_tdata[12:7]);
                check_field("shown_on_hour", due.shown_on_hour, m_tdata[17:13]);
                check_field("shown_off_hour", due.shown_off_hour, m_tdata[22:18]);
                result_count++;
            end
        end
    end

    initial begin
        int ph;
        int phase_events;
        int drain;
        t_in_item press;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 37;
        rx_idle_pct = 65;
        foreach (directed_rows[k]) begin
            deliver_event(directed_rows[k].ev, directed_rows[k].typed, directed_rows[k].want);
        end

        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 65 : 0;
            rx_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 37 : 0;
            phase_events = 0;
            while (phase_events < RANDOM_EVENTS / 3) begin
                if ($urandom_range(29) == 0) begin
                    // Hold the mode button across three polls to force a toggle
                    repeat (HOLD_POLLS) begin
                        press = random_event();
                        press.action = ACT_POLL;
                        press.mode_pin = 1'b1;
                        deliver_event(press, 1'b0, NO_WANT);
                        phase_events++;
                    end
                end else begin
                    deliver_event(random_event(), 1'b0, NO_WANT);
                    phase_events++;
                end
            end
            if (ph == 0) begin
                // Drop valid and let the pipeline empty before the next phase
                s_tvalid <= 1'b0;
                do @(negedge i_clk); while (due_status_q.size() != 0);
            end
        end
        s_tvalid <= 1'b0;

        drain = 0;
        while (due_status_q.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (due_status_q.size() != 0) begin
            fault_count += due_status_q.size();
            $display("%0t ns: %0d expected results never arrived", $time, due_status_q.size());
        end

        $display("Covered %0d events, %0d results checked, %0d mismatches", event_count,
                 result_count, fault_count);
        $display("RTC write requests %0d, mode toggles %0d, edit stage entries %0d",
                 rtc_writes, mode_changes, edit_entries);
        if (fault_count == 0) begin
            $display("PASS hour_timer_switch_controller_core");
        end else begin
            $display("FAIL hour_timer_switch_controller_core");
        end
        $finish;
    end

endmodule

`default_nettype wire
